// ===== hdl/chs_pkg.sv =====
// Package with sizes, command and status codes for the chained hash set engine.
package chs_pkg;
  localparam int NumBuckets = 64;
  localparam int NodeCount  = 256;
  localparam int BktW       = $clog2(NumBuckets);
  localparam int NodeW      = $clog2(NodeCount);
  localparam int LinkW      = $clog2(NodeCount + 1);
  localparam logic [LinkW-1:0] Nil = LinkW'(NodeCount);

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdSearch = 2'd1;
  localparam logic [1:0] CmdRemove = 2'd2;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] entry_count;
  } rsp_t;
endpackage

// ===== hdl/chs_if.sv =====
// Valid/ready channel interface carrying one word of payload.
interface chs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/chs_node_ram.sv =====
// Node pool memory: value and link per node, one port, registered read.
module chs_node_ram import chs_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             wval_i,
  input  logic [NodeW-1:0] addr_i,
  input  logic [31:0]      val_i,
  input  logic [LinkW-1:0] link_i,
  output logic [31:0]      val_o,
  output logic [LinkW-1:0] link_o
);
  logic [31:0]      val_mem [NodeCount];
  logic [LinkW-1:0] link_mem[NodeCount];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      link_mem[addr_i] <= link_i;
      if (wval_i) begin
        val_mem[addr_i] <= val_i;
      end
    end
    val_o  <= val_mem[addr_i];
    link_o <= link_mem[addr_i];
  end
endmodule

// ===== hdl/chained_hash_set_engine_unit.sv =====
// Top level of the chained hash set engine: sequencer, bucket table and node pool.
// The steps are head read (SHead), read and compare per chain node (SRead, SCmp), allocate
// (SAlloc), node write-back for an insert or remove (SWr1, SWr2) and the response (SOut).
// A new command waits until the last response is taken; ready is high only in idle.
// Reset (asynchronous, active low) empties all chains, the free list and the count;
// the node pool needs no clearing since only linked nodes are ever read.
module chained_hash_set_engine_unit import chs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  chs_if.sink   req_i,
  chs_if.source rsp_o
);
  localparam logic [2:0] SIdle = 3'd0, SHead = 3'd1, SRead = 3'd2, SCmp = 3'd3,
                         SAlloc = 3'd4, SWr1 = 3'd5, SWr2 = 3'd6, SOut = 3'd7;

  logic [2:0] state_q, state_d;
  // Bucket heads sit in a memory that is read into a register when a word is accepted.
  // Per-entry valid bits make a head that was never written read as null.
  logic [LinkW-1:0] heads_q [NumBuckets];
  logic [LinkW-1:0] head_q;
  logic [NumBuckets-1:0] hvalid_q;
  logic [LinkW-1:0] free_q, unused_q, cur_q, prev_q, hit_link_q, newn_q;
  logic [8:0]       count_q;
  logic [NodeW:0]   steps_q;
  logic [1:0]       cmd_q, status_q;
  logic [31:0]      val_q;
  logic [BktW-1:0]  bkt_q;
  logic             out_valid_q, wr_phase_q;

  logic             ram_we, ram_wval;
  logic [NodeW-1:0] ram_addr;
  logic [31:0]      ram_val;
  logic [LinkW-1:0] ram_wlink, ram_rlink;
  logic [LinkW-1:0] head_rd;
  logic             alloc_ok, wb_go, head_we;
  logic [LinkW-1:0] head_wdata;

  assign head_rd = hvalid_q[bkt_q] ? head_q : Nil;
  assign req_i.ready = (state_q == SIdle) && !out_valid_q;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = '{status: status_q, entry_count: count_q};

  // A node is available from the free list or from the never-used part of the pool.
  assign alloc_ok = (free_q != Nil) || (unused_q != Nil);
  // A removal that hit, or an insert of a new value with a node to spare, writes back.
  assign wb_go = ((cmd_q == CmdRemove) && wr_phase_q) ||
                 ((cmd_q == CmdInsert) && !wr_phase_q && alloc_ok);
  // The bucket head changes when the affected node has no predecessor.
  assign head_we    = (state_q == SAlloc) && wb_go && (prev_q == Nil);
  assign head_wdata = (cmd_q == CmdRemove) ? hit_link_q :
                      ((free_q != Nil) ? free_q : unused_q);

  chs_node_ram u_ram (
    .clk_i, .we_i(ram_we), .wval_i(ram_wval), .addr_i(ram_addr),
    .val_i(val_q), .link_i(ram_wlink), .val_o(ram_val), .link_o(ram_rlink)
  );

  // Bucket head memory: written in the allocate cycle, read when a word is accepted.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      heads_q[bkt_q] <= head_wdata;
    end
    if (req_i.valid && req_i.ready) begin
      head_q <= heads_q[req_i.data.value[BktW-1:0]];
    end
  end

  // Node memory port control. The walk reads cur; write-backs use the SWr1 and SWr2 states.
  always_comb begin
    ram_we    = 1'b0;
    ram_wval  = 1'b0;
    ram_addr  = cur_q[NodeW-1:0];
    ram_wlink = Nil;
    case (state_q)
      SAlloc: ram_addr = free_q[NodeW-1:0];
      SWr1: begin
        ram_we = 1'b1;
        if (cmd_q == CmdInsert) begin
          ram_addr = newn_q[NodeW-1:0];
          ram_wval = 1'b1;
          ram_wlink = Nil;
        end else begin
          ram_addr  = cur_q[NodeW-1:0];
          ram_wlink = free_q;
        end
      end
      SWr2: begin
        ram_we = prev_q != Nil;
        ram_addr = prev_q[NodeW-1:0];
        ram_wlink = (cmd_q == CmdInsert) ? newn_q : hit_link_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:  if (req_i.valid && req_i.ready) state_d = SHead;
      SHead:  state_d = SRead;
      SRead:  state_d = (cur_q == Nil || steps_q == (NodeW+1)'(NodeCount)) ? SAlloc : SCmp;
      SCmp:   state_d = SRead;
      SAlloc: state_d = wb_go ? SWr1 : SOut;
      SWr1:   state_d = SWr2;
      SWr2:   state_d = SOut;
      SOut:   state_d = SIdle;
      default: state_d = SIdle;
    endcase
    if (state_q == SCmp && ram_val == val_q) state_d = SAlloc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      hvalid_q    <= '0;
      free_q      <= Nil;
      unused_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      wr_phase_q  <= 1'b0;
      cmd_q       <= '0;
      val_q       <= '0;
      bkt_q       <= '0;
      cur_q       <= Nil;
      prev_q      <= Nil;
      steps_q     <= '0;
      hit_link_q  <= Nil;
      newn_q      <= Nil;
      status_q    <= '0;
    end else begin
      state_q <= state_d;
      if (rsp_o.valid && rsp_o.ready) out_valid_q <= 1'b0;
      if (head_we) hvalid_q[bkt_q] <= 1'b1;
      case (state_q)
        SIdle: if (req_i.valid && req_i.ready) begin
          cmd_q <= req_i.data.command;
          val_q <= req_i.data.value;
          // Non-negative modulo: two's complement low bits for a power-of-two bucket count.
          bkt_q <= req_i.data.value[BktW-1:0];
          wr_phase_q <= 1'b0;
        end
        SHead: begin
          cur_q <= head_rd;
          prev_q <= Nil;
          steps_q <= '0;
        end
        SCmp: begin
          if (ram_val == val_q) begin
            wr_phase_q <= 1'b1;     // hit marker
            hit_link_q <= ram_rlink;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= ram_rlink;
            steps_q <= steps_q + 1'b1;
          end
        end
        SAlloc: begin
          // Decide the outcome; a free-list pop reads the link in this cycle.
          if (cmd_q == CmdSearch) begin
            status_q <= wr_phase_q ? StOk : StMiss;
          end else if (cmd_q == CmdRemove) begin
            status_q <= wr_phase_q ? StOk : StMiss;
            if (wr_phase_q && count_q != '0) count_q <= count_q - 1'b1;
          end else if (cmd_q == CmdInsert) begin
            if (wr_phase_q) begin
              status_q <= StMiss;
            end else if (free_q != Nil) begin
              newn_q <= free_q; status_q <= StOk;
            end else if (unused_q != Nil) begin
              newn_q <= unused_q; unused_q <= unused_q + 1'b1;
              status_q <= StOk;
            end else begin
              status_q <= StFull;
            end
            if (!wr_phase_q && alloc_ok) count_q <= count_q + 1'b1;
          end else begin
            status_q <= StMiss;
          end
        end
        SWr1: begin
          // Insert: free-list pop uses the link read during the allocate cycle.
          if (cmd_q == CmdInsert) begin
            if (newn_q == free_q) free_q <= ram_rlink;
          end else begin
            free_q <= cur_q;
          end
        end
        SOut: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> state_q == SIdle) else $error("ready outside idle");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 9'(NodeCount)) else $error("count overflow");
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && status_q == StFull) |-> (free_q == Nil && unused_q == Nil))
    else $error("full reported with nodes left");
`endif
endmodule

// ===== bench/chained_hash_set_engine_unit_test.sv =====
// Self-checking testbench for the chained hash set engine: directed and random commands.
module chained_hash_set_engine_unit_test;
  import chs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;
  localparam logic [1:0] CmdUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  chs_if #(.T(req_t)) req_ch ();
  chs_if #(.T(rsp_t)) rsp_ch ();

  chained_hash_set_engine_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the set: one queue of values per bucket, kept in chain order.
  // Free and never-used nodes are mirrored by count, so the full check follows the real pool use.
  logic signed [31:0] shadow_chain [NumBuckets][$];
  int  shadow_free [$];
  int  shadow_unused;
  int  shadow_count;

  rsp_t expected_rsp [$];
  int   error_count;
  int   rsp_seen;
  int   full_seen;
  int   idle_cycles;
  bit   done;

  // Values sent with insert commands, used to aim random commands at hits.
  logic signed [31:0] known_values [$];

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    shadow_unused = 0;
    shadow_count = 0;
    error_count = 0;
    rsp_seen = 0;
    full_seen = 0;
    idle_cycles = 0;
    done = 1'b0;
  end

  function automatic int bucket_index(logic signed [31:0] v);
    int m;
    m = v % NumBuckets;
    if (m < 0) m += NumBuckets;
    return m;
  endfunction

  // Updates the shadow set for one command and returns the expected response word.
  function automatic rsp_t predict_set(logic [1:0] cmd, logic signed [31:0] v);
    rsp_t r;
    int b;
    int pos;
    b = bucket_index(v);
    pos = -1;
    for (int i = 0; i < shadow_chain[b].size(); i++) begin
      if (pos < 0 && shadow_chain[b][i] == v) pos = i;
    end
    r.status = StMiss;
    case (cmd)
      CmdInsert: begin
        if (pos >= 0) begin
          r.status = StMiss;
        end else if (shadow_free.size() > 0) begin
          void'(shadow_free.pop_front());
          shadow_chain[b].push_back(v);
          shadow_count++;
          r.status = StOk;
        end else if (shadow_unused < NodeCount) begin
          shadow_unused++;
          shadow_chain[b].push_back(v);
          shadow_count++;
          r.status = StOk;
        end else begin
          r.status = StFull;
        end
      end
      CmdSearch: r.status = (pos >= 0) ? StOk : StMiss;
      CmdRemove: begin
        if (pos >= 0) begin
          shadow_chain[b].delete(pos);
          shadow_free.push_front(0);
          shadow_count--;
          r.status = StOk;
        end
      end
      default: r.status = StMiss;
    endcase
    r.entry_count = 9'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Sends one command word, predicting its response when it is accepted.
  task automatic send_word(logic [1:0] cmd, logic signed [31:0] v);
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{command: cmd, value: v};
    do @(posedge clk_i); while (!req_ch.ready);
    expected_rsp.push_back(predict_set(cmd, v));
    if (cmd == CmdInsert) known_values.push_back(v);
    if (expected_rsp[$].status == StFull) full_seen++;
  endtask

  task automatic pause_sender(int cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp.size() > 0) @(posedge clk_i);
  endtask

  // Receiver stalls on its own pattern: random runs of ready low, and calm stretches.
  initial begin : receiver_pattern
    int mode;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        @(posedge clk_i);
        if (mode == 0) rsp_ch.ready <= 1'b1;
        else rsp_ch.ready <= ($urandom_range(0, 3) >= mode - 1);
      end
    end
  end

  // Checks each accepted response word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      rsp_seen++;
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected response, status", rsp_ch.data.status, -1);
      end else begin
        if (rsp_ch.data.status !== expected_rsp[0].status)
          report_mismatch("status", rsp_ch.data.status, expected_rsp[0].status);
        if (rsp_ch.data.entry_count !== expected_rsp[0].entry_count)
          report_mismatch("entry_count", rsp_ch.data.entry_count,
                          expected_rsp[0].entry_count);
        void'(expected_rsp.pop_front());
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("chained_hash_set_engine_unit regression: fail");
      $finish;
    end
  end

  // Extremes of the value range, negative remainders, duplicates, misses and the unused code.
  task automatic test_directed();
    send_word(CmdSearch, 32'sh0000_0000);
    send_word(CmdRemove, 32'sh7fff_ffff);
    send_word(CmdInsert, 32'sh8000_0000);
    send_word(CmdInsert, 32'sh7fff_ffff);
    send_word(CmdInsert, -32'sd1);
    send_word(CmdInsert, 32'sd63);
    send_word(CmdInsert, -32'sd65);
    send_word(CmdInsert, 32'sd0);
    send_word(CmdInsert, 32'sd64);
    send_word(CmdInsert, 32'sd128);
    send_word(CmdInsert, 32'sd64);
    send_word(CmdSearch, 32'sd64);
    send_word(CmdSearch, 32'sd192);
    send_word(CmdRemove, 32'sd64);
    send_word(CmdSearch, 32'sd128);
    send_word(CmdRemove, 32'sd64);
    send_word(CmdUnused, 32'sd0);
    send_word(CmdUnused, -32'sd1);
    send_word(CmdRemove, 32'sd0);
    send_word(CmdInsert, 32'sd256);
    send_word(CmdSearch, 32'sh8000_0000);
    send_word(CmdRemove, -32'sd1);
    drain_results();
  endtask

  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (known_values.size() > 0 && sel < 5)
      return known_values[$urandom_range(0, known_values.size() - 1)];
    if (sel < 8) return 32'($urandom_range(0, 2047)) - 32'sd1024;
    return $urandom;
  endfunction

  // Random traffic in bursts; the insert weight sets whether the mix fills or empties the table.
  task automatic test_random(int count, int insert_weight);
    int burst;
    int sent;
    int pick;
    logic [1:0] cmd;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < insert_weight) cmd = CmdInsert;
        else if (pick < 97) cmd = (pick & 1) ? CmdSearch : CmdRemove;
        else cmd = CmdUnused;
        send_word(cmd, pick_value());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    if (known_values.size() > 600) known_values.delete();
  endtask

  // Fills the pool past its size so inserts report full, then frees nodes for reuse.
  task automatic test_pool_full();
    repeat (NodeCount + 10 - shadow_count) send_word(CmdInsert, $urandom);
    repeat (40) send_word(CmdRemove, known_values[$urandom_range(0, known_values.size() - 1)]);
    repeat (30) send_word(CmdInsert, $urandom);
    drain_results();
  endtask

  initial begin : main_sequence
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300, 70);
    drain_results();
    test_pool_full();
    test_random(300, 30);
    test_random(200, 55);
    drain_results();
    repeat (40) @(posedge clk_i);
    done = 1'b1;
    $display("covered insert, search, remove and the unused code over %0d responses,",
             rsp_seen);
    $display("with %0d pool-full refusals and node reuse from the free list", full_seen);
    if (error_count == 0 && expected_rsp.size() == 0) begin
      $display("chained_hash_set_engine_unit regression: pass");
    end else begin
      $display("chained_hash_set_engine_unit regression: fail");
    end
    $finish;
  end
endmodule
